### rtl/s2d_pkg.sv
// shared types, constants and microcode table for the signed integer to ascii converter
package s2d_pkg;

    localparam int STEP_W = 3;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_NL    = 7'h0A;

    localparam logic [STEP_W-1:0] ST_ACCEPT   = 3'd0;
    localparam logic [STEP_W-1:0] ST_SIGN_CHK = 3'd1;
    localparam logic [STEP_W-1:0] ST_MINUS    = 3'd2;
    localparam logic [STEP_W-1:0] ST_ZERO_CHK = 3'd3;
    localparam logic [STEP_W-1:0] ST_DIVIDE   = 3'd4;
    localparam logic [STEP_W-1:0] ST_DIGIT    = 3'd5;
    localparam logic [STEP_W-1:0] ST_NEWLINE  = 3'd6;
    localparam logic [STEP_W-1:0] ST_ZERO     = 3'd7;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_MINUS,
        EM_DIGIT,
        EM_ZERO,
        EM_NL
    } emit_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_DEC
    } op_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_IN,
        JC_POS,
        JC_MAG_ZERO,
        JC_DIV_MORE,
        JC_CNT_MORE
    } jcond_t;

    typedef struct packed {
        emit_t              emit;
        op_t                op;
        jcond_t             cond;
        logic [STEP_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic neg;
        logic mag_zero;
        logic div_more;
        logic cnt_more;
    } s2d_flags_t;

    typedef struct packed {
        ucode_t uc;
        logic   go;
    } s2d_exec_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            ST_ACCEPT:   w = '{EM_NONE,  OP_LOAD, JC_NO_IN,    ST_ACCEPT};
            ST_SIGN_CHK: w = '{EM_NONE,  OP_NONE, JC_POS,      ST_ZERO_CHK};
            ST_MINUS:    w = '{EM_MINUS, OP_NONE, JC_NEXT,     ST_ACCEPT};
            ST_ZERO_CHK: w = '{EM_NONE,  OP_NONE, JC_MAG_ZERO, ST_ZERO};
            ST_DIVIDE:   w = '{EM_NONE,  OP_DIV,  JC_DIV_MORE, ST_DIVIDE};
            ST_DIGIT:    w = '{EM_DIGIT, OP_DEC,  JC_CNT_MORE, ST_DIGIT};
            ST_NEWLINE:  w = '{EM_NL,    OP_NONE, JC_ALWAYS,   ST_ACCEPT};
            ST_ZERO:     w = '{EM_ZERO,  OP_NONE, JC_ALWAYS,   ST_NEWLINE};
        endcase
        return w;
    endfunction

endpackage

### rtl/s2d_in_if.sv
// input channel carrying one signed value per word
interface s2d_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

### rtl/s2d_out_if.sv
// output channel carrying one ascii character per word
interface s2d_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink (input valid, input char_out, input last, output ready);
endinterface

### rtl/s2d_useq.sv
// microcode sequencer: step counter, control store and conditional jumps
module s2d_useq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  s2d_pkg::s2d_flags_t   flags,
    output s2d_pkg::s2d_exec_t    exec
);

    logic [s2d_pkg::STEP_W-1:0] step_reg;
    logic [s2d_pkg::STEP_W-1:0] step_next;
    s2d_pkg::ucode_t            uc;
    logic                       taken;
    logic                       go;

    always_comb
    begin
        uc = s2d_pkg::ucode_rom(step_reg);
        go = (uc.emit == s2d_pkg::EM_NONE) || flags.out_free;
        unique case (uc.cond)
            s2d_pkg::JC_NEXT:     taken = 1'b0;
            s2d_pkg::JC_ALWAYS:   taken = 1'b1;
            s2d_pkg::JC_NO_IN:    taken = !flags.in_valid;
            s2d_pkg::JC_POS:      taken = !flags.neg;
            s2d_pkg::JC_MAG_ZERO: taken = flags.mag_zero;
            s2d_pkg::JC_DIV_MORE: taken = flags.div_more;
            s2d_pkg::JC_CNT_MORE: taken = flags.cnt_more;
            default:              taken = 1'b0;
        endcase
        if (!go)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = uc.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
        exec.uc = uc;
        exec.go = go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= s2d_pkg::ST_ACCEPT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_load_only_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.op == s2d_pkg::OP_LOAD) |-> (step_reg == s2d_pkg::ST_ACCEPT))
        else $error("load issued outside the accept step");

    a_stall_holds_step: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(step_reg))
        else $error("step moved while output was stalled");

    a_newline_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == s2d_pkg::ST_NEWLINE && go) |=> (step_reg == s2d_pkg::ST_ACCEPT))
        else $error("newline step did not return to accept");

endmodule

### rtl/signed_int_to_decimal_ascii_core.sv
// top level: signed 32-bit integer to decimal ascii text, one character per output word
//
// Each input word is a two's complement value; the block sends a '-' for negative
// values, the decimal digits most significant first without leading zeros, and a
// newline word with last set. Zero prints as "0". The most negative value prints in
// full. Control is a microcoded sequencer; the datapath finds one digit per cycle by
// reciprocal multiply and, while the output is not stalled, sends one character per
// cycle through a single output register. Steps run accept, sign check, minus (if
// negative), zero check, divide and digit (or zero for a zero input), then newline;
// a stalled output holds the step. The next word is taken only when the previous
// text has been handed to the output register. If DIGIT_SLOTS is below the digit
// count only its lowest-order digits are printed.
module signed_int_to_decimal_ascii_core
#(
    parameter int DIGIT_SLOTS = 10
)
(
    input  logic         clk,
    input  logic         rst_n,
    s2d_in_if.sink       din,
    s2d_out_if.source    dout
);

    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int IDX_W = $clog2(DIGIT_SLOTS);

    s2d_pkg::s2d_flags_t flags;
    s2d_pkg::s2d_exec_t  exec;

    logic [31:0]      mag_reg;
    logic [31:0]      mag_next;
    logic             neg_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;
    logic [3:0]       store_reg [DIGIT_SLOTS];
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [6:0]       char_reg;
    logic [6:0]       char_next;
    logic             last_reg;
    logic             last_next;

    logic [63:0]      prod;
    logic [28:0]      quot;
    logic [31:0]      quot_x10;
    logic [3:0]       rem;
    logic [3:0]       digit_rd;
    logic             do_emit;

    s2d_useq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .exec  (exec)
    );

    always_comb
    begin
        prod      = {32'd0, mag_reg} * 64'h0000_0000_CCCC_CCCD;
        quot      = prod[63:35];
        quot_x10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem       = 4'(mag_reg - quot_x10);
        count_inc = count_reg + 1'b1;
        count_dec = count_reg - 1'b1;
        digit_rd  = store_reg[count_dec[IDX_W-1:0]];

        flags.in_valid = din.valid;
        flags.out_free = !out_valid_reg || dout.ready;
        flags.neg      = neg_reg;
        flags.mag_zero = (mag_reg == 32'd0);
        flags.div_more = (quot != 29'd0) && (count_inc < CNT_W'(DIGIT_SLOTS));
        flags.cnt_more = (count_dec != '0);

        din.ready = (exec.uc.op == s2d_pkg::OP_LOAD);

        mag_next   = mag_reg;
        count_next = count_reg;
        case (exec.uc.op)
            s2d_pkg::OP_LOAD:
            begin
                mag_next   = din.value[31] ? (32'd0 - 32'(din.value)) : 32'(din.value);
                count_next = '0;
            end
            s2d_pkg::OP_DIV:
            begin
                mag_next   = {3'b000, quot};
                count_next = count_inc;
            end
            s2d_pkg::OP_DEC:
            begin
                count_next = exec.go ? count_dec : count_reg;
            end
            default:
            begin
                mag_next   = mag_reg;
                count_next = count_reg;
            end
        endcase

        do_emit   = exec.go && (exec.uc.emit != s2d_pkg::EM_NONE);
        char_next = char_reg;
        last_next = last_reg;
        case (exec.uc.emit)
            s2d_pkg::EM_MINUS: char_next = s2d_pkg::CH_MINUS;
            s2d_pkg::EM_DIGIT: char_next = s2d_pkg::CH_ZERO + {3'b000, digit_rd};
            s2d_pkg::EM_ZERO:  char_next = s2d_pkg::CH_ZERO;
            s2d_pkg::EM_NL:    char_next = s2d_pkg::CH_NL;
            default:           char_next = char_reg;
        endcase
        if (do_emit)
        begin
            last_next = (exec.uc.emit == s2d_pkg::EM_NL);
        end

        if (do_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        dout.valid    = out_valid_reg;
        dout.char_out = char_reg;
        dout.last     = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            mag_reg       <= mag_next;
            if (exec.uc.op == s2d_pkg::OP_LOAD)
            begin
                neg_reg <= din.value[31];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
        if (exec.uc.op == s2d_pkg::OP_DIV)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= rem;
        end
    end

    a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("ready stayed high after a word was taken");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DIGIT_SLOTS))
        else $error("digit count beyond store size");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.last) |->
            ((dout.char_out == s2d_pkg::CH_MINUS) ||
             ((dout.char_out >= s2d_pkg::CH_ZERO) && (dout.char_out <= 7'h39))))
        else $error("illegal character before newline");

    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.last) |-> (dout.char_out == s2d_pkg::CH_NL))
        else $error("last word is not a newline");

endmodule
